/* hdl/cpc_pkg.sv */
// cpc_pkg: shared types and constants for the card punch controller
// status and control bit positions, command and outcome codes, result struct
// no dependencies
package cpc_pkg;

  localparam int unsigned WordW  = 18;
  localparam int unsigned CountW = 7;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned OutcW  = 2;
  localparam int unsigned LevelW = 3;

  // command codes
  localparam logic [CmdW-1:0] CMD_CONI  = 3'd0;
  localparam logic [CmdW-1:0] CMD_CONO  = 3'd1;
  localparam logic [CmdW-1:0] CMD_DATAI = 3'd2;
  localparam logic [CmdW-1:0] CMD_DATAO = 3'd3;
  localparam logic [CmdW-1:0] CMD_TICK  = 3'd4;

  // punch mechanism outcome codes
  localparam logic [OutcW-1:0] OUTC_OK       = 2'd0;
  localparam logic [OutcW-1:0] OUTC_PICK_F   = 2'd1;
  localparam logic [OutcW-1:0] OUTC_EJECT_F  = 2'd2;

  // status word bits
  localparam logic [WordW-1:0] ST_LEVEL    = 18'o0000007;
  localparam logic [WordW-1:0] ST_DREQ     = 18'o0000010;
  localparam logic [WordW-1:0] ST_PUNCH_ON = 18'o0000040;
  localparam logic [WordW-1:0] ST_END_CARD = 18'o0000100;
  localparam logic [WordW-1:0] ST_END_EN   = 18'o0000200;
  localparam logic [WordW-1:0] ST_CARD_IN  = 18'o0000400;
  localparam logic [WordW-1:0] ST_ERROR    = 18'o0001000;
  localparam logic [WordW-1:0] ST_TRBL_EN  = 18'o0002000;
  localparam logic [WordW-1:0] ST_TRBL     = 18'o0004000;
  localparam logic [WordW-1:0] ST_EJECT_F  = 18'o0010000;
  localparam logic [WordW-1:0] ST_PICK_F   = 18'o0020000;

  // control write bits
  localparam logic [WordW-1:0] CO_SET_DREQ  = 18'o0000010;
  localparam logic [WordW-1:0] CO_CLR_DREQ  = 18'o0000020;
  localparam logic [WordW-1:0] CO_PUNCH_ON  = 18'o0000040;
  localparam logic [WordW-1:0] CO_CLR_END   = 18'o0000100;
  localparam logic [WordW-1:0] CO_EN_END    = 18'o0000200;
  localparam logic [WordW-1:0] CO_DIS_END   = 18'o0000400;
  localparam logic [WordW-1:0] CO_EN_TRBL   = 18'o0002000;
  localparam logic [WordW-1:0] CO_DIS_TRBL  = 18'o0004000;
  localparam logic [WordW-1:0] CO_EJECT     = 18'o0010000;
  localparam logic [WordW-1:0] CO_CLR_PUNCH = 18'o0100000;

  typedef struct packed {
    logic [WordW-1:0]  read_data;
    logic              irq_raise;
    logic              irq_lower;
    logic [LevelW-1:0] irq_level;
    logic              column_valid;
    logic [CountW-1:0] column_index;
    logic [CodeW-1:0]  column_code;
    logic              card_done;
  } cpc_result_t;

endpackage

/* hdl/cpc_step.sv */
// cpc_step: next status word, column counter and result for one transfer
// purely combinational; uses cpc_pkg
module cpc_step #(
  parameter int unsigned CARD_COLUMNS = 80
) (
  input  logic [cpc_pkg::CmdW-1:0]   cmd,
  input  logic [cpc_pkg::WordW-1:0]  bus_data,
  input  logic [cpc_pkg::OutcW-1:0]  punch_outcome,
  input  logic [cpc_pkg::WordW-1:0]  status,
  input  logic [cpc_pkg::CountW-1:0] count,
  output logic [cpc_pkg::WordW-1:0]  status_nxt,
  output logic [cpc_pkg::CountW-1:0] count_nxt,
  output cpc_pkg::cpc_result_t       result
);

  localparam logic [cpc_pkg::CountW-1:0] Columns = cpc_pkg::CountW'(CARD_COLUMNS);

  logic [cpc_pkg::WordW-1:0] s;
  logic                      card_full;

  assign card_full = (count >= Columns);

  // read-modify-write of the status word
  always_comb begin
    s         = status;
    count_nxt = count;
    result    = '0;
    unique case (cmd)
      cpc_pkg::CMD_CONI: begin
        result.read_data = status;
      end
      cpc_pkg::CMD_CONO: begin
        result.irq_lower = 1'b1;
        s = (s & ~cpc_pkg::ST_LEVEL) | (bus_data & cpc_pkg::ST_LEVEL);
        if ((bus_data & cpc_pkg::CO_CLR_PUNCH) != '0) begin
          s = s & ~(cpc_pkg::ST_TRBL | cpc_pkg::ST_ERROR | cpc_pkg::ST_END_CARD |
                    cpc_pkg::ST_END_EN | cpc_pkg::ST_TRBL_EN);
        end else begin
          if ((bus_data & cpc_pkg::CO_SET_DREQ) != '0) begin
            s = s | cpc_pkg::ST_DREQ;
            result.irq_raise = 1'b1;
          end
          if ((bus_data & cpc_pkg::CO_CLR_DREQ) != '0) s = s & ~cpc_pkg::ST_DREQ;
          if ((bus_data & cpc_pkg::CO_CLR_END) != '0)  s = s & ~cpc_pkg::ST_END_CARD;
          if ((bus_data & cpc_pkg::CO_EN_END) != '0)   s = s | cpc_pkg::ST_END_EN;
          if ((bus_data & cpc_pkg::CO_DIS_END) != '0)  s = s & ~cpc_pkg::ST_END_EN;
          if ((bus_data & cpc_pkg::CO_EN_TRBL) != '0)  s = s | cpc_pkg::ST_TRBL_EN;
          if ((bus_data & cpc_pkg::CO_DIS_TRBL) != '0) s = s & ~cpc_pkg::ST_TRBL_EN;
          // eject jumps the counter to the end of the card
          if (((bus_data & cpc_pkg::CO_EJECT) != '0) &&
              ((s & cpc_pkg::ST_CARD_IN) != '0)) begin
            count_nxt = Columns;
            s = s & ~cpc_pkg::ST_DREQ;
          end
          if ((s & (cpc_pkg::ST_TRBL | cpc_pkg::ST_TRBL_EN)) ==
              (cpc_pkg::ST_TRBL | cpc_pkg::ST_TRBL_EN)) result.irq_raise = 1'b1;
          if ((s & (cpc_pkg::ST_END_CARD | cpc_pkg::ST_END_EN)) ==
              (cpc_pkg::ST_END_CARD | cpc_pkg::ST_END_EN)) result.irq_raise = 1'b1;
          if ((bus_data & cpc_pkg::CO_PUNCH_ON) != '0) s = s | cpc_pkg::ST_PUNCH_ON;
        end
      end
      cpc_pkg::CMD_DATAO: begin
        // forward the column unless the card is full
        if (!card_full) begin
          result.column_valid = 1'b1;
          result.column_index = count;
          result.column_code  = bus_data[cpc_pkg::CodeW-1:0];
          count_nxt           = count + 1'b1;
        end
        s = s & ~cpc_pkg::ST_DREQ;
        result.irq_lower = 1'b1;
      end
      cpc_pkg::CMD_TICK: begin
        if ((s & cpc_pkg::ST_PUNCH_ON) != '0) begin
          s = s | cpc_pkg::ST_CARD_IN;
          if ((s & cpc_pkg::ST_DREQ) != '0) begin
            // still waiting for the column write
            s = s;
          end else if (!card_full) begin
            s = s | cpc_pkg::ST_DREQ;
            result.irq_raise = 1'b1;
          end else begin
            // card finished
            count_nxt = '0;
            s = s & ~(cpc_pkg::ST_PUNCH_ON | cpc_pkg::ST_CARD_IN);
            s = s | cpc_pkg::ST_END_CARD;
            result.card_done = 1'b1;
            if (punch_outcome == cpc_pkg::OUTC_PICK_F)
              s = s | cpc_pkg::ST_PICK_F | cpc_pkg::ST_TRBL;
            else if (punch_outcome == cpc_pkg::OUTC_EJECT_F)
              s = s | cpc_pkg::ST_EJECT_F | cpc_pkg::ST_TRBL;
            if ((s & (cpc_pkg::ST_TRBL | cpc_pkg::ST_TRBL_EN)) ==
                (cpc_pkg::ST_TRBL | cpc_pkg::ST_TRBL_EN)) result.irq_raise = 1'b1;
            if ((s & cpc_pkg::ST_END_EN) != '0) result.irq_raise = 1'b1;
          end
        end
      end
      default: begin
        // data read and unused commands leave the state alone
        s = s;
      end
    endcase
    status_nxt       = s;
    result.irq_level = s[cpc_pkg::LevelW-1:0];
  end

endmodule

/* hdl/card_punch_controller.sv */
// card_punch_controller: top level, input register, state and result register
// depends on cpc_pkg and cpc_step
//
// Each transfer on the in_ channel (status read, control write, data read,
// data write or service tick) yields exactly one transfer on the out_ channel.
// An item is captured in an input register; the status word and column counter
// are updated from it when it advances, while its result is loaded into the
// output register. A new item is taken every cycle as long as out_ready keeps
// the output register draining. The single status read-modify-write between
// the two registers sets that rate.
// CARD_COLUMNS sets the number of columns on a card (1 to 127).
module card_punch_controller #(
  parameter int unsigned CARD_COLUMNS = 80
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cpc_pkg::CmdW-1:0]      in_cmd,
  input  logic [cpc_pkg::WordW-1:0]     in_bus_data,
  input  logic [cpc_pkg::OutcW-1:0]     in_punch_outcome,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cpc_pkg::WordW-1:0]     out_read_data,
  output logic                          out_irq_raise,
  output logic                          out_irq_lower,
  output logic [cpc_pkg::LevelW-1:0]    out_irq_level,
  output logic                          out_column_valid,
  output logic [cpc_pkg::CountW-1:0]    out_column_index,
  output logic [cpc_pkg::CodeW-1:0]     out_column_code,
  output logic                          out_card_done
);

  logic                        s1_valid_r;
  logic [cpc_pkg::CmdW-1:0]    s1_cmd_r;
  logic [cpc_pkg::WordW-1:0]   s1_bus_r;
  logic [cpc_pkg::OutcW-1:0]   s1_outc_r;

  logic [cpc_pkg::WordW-1:0]   status_r, status_nxt;
  logic [cpc_pkg::CountW-1:0]  count_r, count_nxt;

  logic                        out_valid_r;
  cpc_pkg::cpc_result_t        res_r, res_nxt;

  logic advance;
  logic in_xfer;

  // pipeline flow control
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_xfer) begin
      s1_cmd_r  <= in_cmd;
      s1_bus_r  <= in_bus_data;
      s1_outc_r <= in_punch_outcome;
    end
  end

  cpc_step #(
    .CARD_COLUMNS(CARD_COLUMNS)
  ) u_step (
    .cmd          (s1_cmd_r),
    .bus_data     (s1_bus_r),
    .punch_outcome(s1_outc_r),
    .status       (status_r),
    .count        (count_r),
    .status_nxt   (status_nxt),
    .count_nxt    (count_nxt),
    .result       (res_nxt)
  );

  // state update and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        status_r <= status_nxt;
        count_r  <= count_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = res_r.read_data;
  assign out_irq_raise    = res_r.irq_raise;
  assign out_irq_lower    = res_r.irq_lower;
  assign out_irq_level    = res_r.irq_level;
  assign out_column_valid = res_r.column_valid;
  assign out_column_index = res_r.column_index;
  assign out_column_code  = res_r.column_code;
  assign out_card_done    = res_r.card_done;

endmodule
